[design/rbct_pkg.sv]
`default_nettype none
package rbct_pkg;

  typedef enum logic [2:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_MIN  = 3'd2,
    REG_VAL_MIN  = 3'd3,
    REG_MIN_PIX  = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned SumW     = 30;
  localparam int unsigned TallyW   = 21;
  localparam int unsigned CoordW   = 11;
  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};
  localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_e;

  // frame summary handed from the accumulator to the divider
  typedef struct packed {
    logic              found;
    logic [SumW-1:0]   sum_x;
    logic [SumW-1:0]   sum_y;
    logic [TallyW-1:0] tally;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
  } frame_t;

  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [TallyW-1:0] red_count;
  } result_t;

endpackage
`default_nettype wire

[design/rbct_if.sv]
`default_nettype none
interface rbct_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_in_frame;
  modport source (output valid, red, green, blue, last_in_frame, input ready);
  modport sink   (input valid, red, green, blue, last_in_frame, output ready);
endinterface

interface rbct_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [10:0] center_x;
  logic [10:0] center_y;
  logic [20:0] red_count;
  modport source (output valid, found, center_x, center_y, red_count, input ready);
  modport sink   (input valid, found, center_x, center_y, red_count, output ready);
endinterface

interface rbct_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [20:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/rbct_front.sv]
`default_nettype none
module rbct_front #(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxHeight = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     pix_valid_i,
  output logic                          pix_ready_o,
  input  wire logic [7:0]               red_i,
  input  wire logic [7:0]               green_i,
  input  wire logic [7:0]               blue_i,
  input  wire logic                     last_i,
  input  wire logic [8:0]               hue_low_i,
  input  wire logic [8:0]               hue_high_i,
  input  wire logic [6:0]               sat_min_i,
  input  wire logic [6:0]               val_min_i,
  input  wire logic [20:0]              min_pix_i,
  input  wire logic [10:0]              width_i,
  input  wire logic [10:0]              height_i,
  output logic                          frm_valid_o,
  input  wire logic                     frm_ready_i,
  output rbct_pkg::frame_t              frm_o
);
  localparam int unsigned ColW = $clog2(MaxWidth + 1);
  localparam int unsigned RowW = $clog2(MaxHeight + 1);

  // stage 1: colour classify registered
  logic       s1_valid_q, s1_red_q, s1_last_q;
  logic       s1_red_d;
  logic       s1_ready;
  // stage 2: accumulate
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [rbct_pkg::SumW-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic [rbct_pkg::TallyW-1:0] tally_q, tally_d;
  logic [12:0] w_eff, h_eff;
  logic [ColW-1:0] col_c;
  logic [RowW-1:0] row_c;
  logic [rbct_pkg::SumW:0] ax, ay;

  logic [7:0]  mx, mn, d;
  logic [17:0] num, lo_lim, hi_lim;
  logic [15:0] v100, v_lim, s100, s_lim;
  logic        hue_ok, sat_ok, val_ok;

  // thresholds compared against cross products, so no divide is needed
  always_comb begin
    mx = red_i; if (green_i > mx) mx = green_i; if (blue_i > mx) mx = blue_i;
    mn = red_i; if (green_i < mn) mn = green_i; if (blue_i < mn) mn = blue_i;
    d = mx - mn;
    v100  = 16'(mx) * 16'd100;
    v_lim = 16'd255 * (16'(val_min_i) + 16'd1);
    s100  = 16'(d) * 16'd100;
    s_lim = 16'(mx) * (16'(sat_min_i) + 16'd1);
    val_ok = v100 >= v_lim;
    sat_ok = (mx != 8'd0) && (s100 >= s_lim);
    if (red_i >= green_i && red_i >= blue_i) begin
      if (green_i >= blue_i) num = 18'd60 * 18'(green_i - blue_i);
      else num = 18'd360 * 18'(d) - 18'd60 * 18'(blue_i - green_i);
    end else if (blue_i >= green_i) begin
      if (blue_i == green_i) num = 18'd120 * 18'(d) + 18'd60 * 18'(blue_i - red_i);
      else num = 18'd240 * 18'(d) + 18'd60 * 18'(red_i) - 18'd60 * 18'(green_i);
    end else begin
      num = 18'd120 * 18'(d) + 18'd60 * 18'(blue_i) - 18'd60 * 18'(red_i);
    end
    lo_lim = 18'(hue_low_i) * 18'(d);
    hi_lim = (18'(hue_high_i) + 18'd1) * 18'(d);
    // grey pixel has hue zero
    hue_ok = (d == 8'd0) ? (hue_low_i != 9'd0) : (num < lo_lim || num >= hi_lim);
    s1_red_d = hue_ok && sat_ok && val_ok;
  end

  always_ff @(posedge clk_i) begin
    if (pix_valid_i && pix_ready_o) begin
      s1_red_q  <= s1_red_d;
      s1_last_q <= last_i;
    end
  end

  assign s1_ready    = !(s1_last_q && frm_valid_o && !frm_ready_i);
  assign pix_ready_o = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      s1_valid_q <= pix_valid_i;
    end
  end

  always_comb begin
    w_eff = (width_i == 11'd0) ? 13'd1 :
            (13'(width_i) > 13'(MaxWidth)) ? 13'(MaxWidth) : 13'(width_i);
    h_eff = (height_i == 11'd0) ? 13'd1 :
            (13'(height_i) > 13'(MaxHeight)) ? 13'(MaxHeight) : 13'(height_i);
    col_c = (13'(col_q) >= w_eff) ? '0 : col_q;
    row_c = (13'(row_q) >= h_eff) ? '0 : row_q;
    ax = {1'b0, sx_q} + (rbct_pkg::SumW+1)'(col_c);
    ay = {1'b0, sy_q} + (rbct_pkg::SumW+1)'(row_c);
    sx_d = sx_q; sy_d = sy_q; tally_d = tally_q;
    if (s1_red_q && tally_q != rbct_pkg::TallyMax) begin
      sx_d = ax[rbct_pkg::SumW] ? rbct_pkg::SumMax : ax[rbct_pkg::SumW-1:0];
      sy_d = ay[rbct_pkg::SumW] ? rbct_pkg::SumMax : ay[rbct_pkg::SumW-1:0];
      tally_d = tally_q + 1'b1;
    end
    col_d = col_c + 1'b1;
    row_d = row_c;
    if (13'(col_d) >= w_eff) begin
      col_d = '0;
      row_d = row_c + 1'b1;
      if (13'(row_d) >= h_eff) row_d = '0;
    end
    frm_o.found = tally_d > min_pix_i;
    frm_o.sum_x = sx_d;
    frm_o.sum_y = sy_d;
    frm_o.tally = tally_d;
    frm_o.w     = 11'(w_eff);
    frm_o.h     = 11'(h_eff);
  end

  assign frm_valid_o = s1_valid_q && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; sx_q <= '0; sy_q <= '0; tally_q <= '0;
    end else if (s1_valid_q && s1_ready) begin
      if (s1_last_q) begin
        col_q <= '0; row_q <= '0; sx_q <= '0; sy_q <= '0; tally_q <= '0;
      end else begin
        col_q <= col_d; row_q <= row_d; sx_q <= sx_d; sy_q <= sy_d; tally_q <= tally_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_valid_o && !frm_ready_i |=> frm_valid_o && $stable(tally_q))
    else $error("frame beat lost while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_valid_o && frm_ready_i |=> tally_q == '0)
    else $error("tally not cleared at frame end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q != '0 |-> sx_q <= rbct_pkg::SumMax)
    else $error("sum out of range");
endmodule
`default_nettype wire

[design/rbct_divider.sv]
`default_nettype none
module rbct_divider (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             frm_valid_i,
  output logic                  frm_ready_o,
  input  wire rbct_pkg::frame_t frm_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output rbct_pkg::result_t     res_o
);
  localparam int unsigned SumW = rbct_pkg::SumW;
  localparam int unsigned TW   = rbct_pkg::TallyW;
  localparam int unsigned CntW = $clog2(SumW + 1);

  rbct_pkg::div_state_e state_q, state_d;
  rbct_pkg::frame_t     frm_q;
  logic [SumW-1:0] qx_q, qy_q;
  logic [TW:0]     rx_q, ry_q;
  logic [CntW-1:0] cnt_q;
  logic [TW:0]     tx, ty;
  logic [TW:0]     dvs;

  assign dvs = {1'b0, frm_q.tally};
  assign tx  = {rx_q[TW-1:0], qx_q[SumW-1]};
  assign ty  = {ry_q[TW-1:0], qy_q[SumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rbct_pkg::DIV_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    frm_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      rbct_pkg::DIV_IDLE: begin
        frm_ready_o = 1'b1;
        if (frm_valid_i) state_d = rbct_pkg::DIV_RUN;
      end
      rbct_pkg::DIV_RUN: begin
        if (cnt_q == CntW'(SumW - 1)) state_d = rbct_pkg::DIV_DONE;
      end
      rbct_pkg::DIV_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = rbct_pkg::DIV_IDLE;
      end
      default: state_d = rbct_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rbct_pkg::DIV_IDLE && frm_valid_i) begin
      frm_q <= frm_i;
      qx_q  <= frm_i.sum_x;
      qy_q  <= frm_i.sum_y;
      rx_q  <= '0;
      ry_q  <= '0;
      cnt_q <= '0;
    end else if (state_q == rbct_pkg::DIV_RUN) begin
      cnt_q <= cnt_q + 1'b1;
      if (tx >= dvs) begin
        rx_q <= tx - dvs; qx_q <= {qx_q[SumW-2:0], 1'b1};
      end else begin
        rx_q <= tx;       qx_q <= {qx_q[SumW-2:0], 1'b0};
      end
      if (ty >= dvs) begin
        ry_q <= ty - dvs; qy_q <= {qy_q[SumW-2:0], 1'b1};
      end else begin
        ry_q <= ty;       qy_q <= {qy_q[SumW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    res_o.found     = frm_q.found;
    res_o.red_count = frm_q.tally;
    res_o.center_x  = frm_q.found ? qx_q[rbct_pkg::CoordW-1:0] : frm_q.w;
    res_o.center_y  = frm_q.found ? qy_q[rbct_pkg::CoordW-1:0] : frm_q.h;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !frm_ready_o)
    else $error("divider accepts while holding a result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.found |-> res_o.red_count != '0)
    else $error("found with empty tally");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

[design/red_blob_centroid_tracker.sv]
`default_nettype none
// channel  dir  beat
// pix      in   red, green, blue, last_in_frame
// res      out  found, center_x, center_y, red_count
// cfg      in   index, data
// one pixel a cycle: hsv classify stage, then accumulate stage
// result valid after the last pixel beat of a frame once the divider is idle, takes the frame and runs its divide
// the serial divider takes a new frame only after its last result has been taken
// pixels stall only when a frame end waits behind a busy divider
// reset restores register defaults and clears position, sums and tally
module red_blob_centroid_tracker #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  rbct_pix_if.sink   pix,
  rbct_res_if.source res,
  rbct_cfg_if.sink   cfg
);
  logic [8:0]  hue_low_q, hue_high_q;
  logic [6:0]  sat_min_q, val_min_q;
  logic [20:0] min_pix_q;
  logic [10:0] width_q, height_q;
  logic              frm_valid, frm_ready;
  rbct_pkg::frame_t  frm;
  rbct_pkg::result_t rs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q <= 9'd10; hue_high_q <= 9'd345; sat_min_q <= 7'd75; val_min_q <= 7'd75;
      min_pix_q <= 21'd15; width_q <= 11'd640; height_q <= 11'd480;
    end else if (cfg.valid) begin
      case (rbct_pkg::reg_idx_e'(cfg.index))
        rbct_pkg::REG_HUE_LOW:  hue_low_q  <= cfg.data[8:0];
        rbct_pkg::REG_HUE_HIGH: hue_high_q <= cfg.data[8:0];
        rbct_pkg::REG_SAT_MIN:  sat_min_q  <= cfg.data[6:0];
        rbct_pkg::REG_VAL_MIN:  val_min_q  <= cfg.data[6:0];
        rbct_pkg::REG_MIN_PIX:  min_pix_q  <= cfg.data;
        rbct_pkg::REG_WIDTH:    width_q    <= cfg.data[10:0];
        rbct_pkg::REG_HEIGHT:   height_q   <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  rbct_front #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni,
    .pix_valid_i(pix.valid), .pix_ready_o(pix.ready),
    .red_i(pix.red), .green_i(pix.green), .blue_i(pix.blue), .last_i(pix.last_in_frame),
    .hue_low_i(hue_low_q), .hue_high_i(hue_high_q), .sat_min_i(sat_min_q),
    .val_min_i(val_min_q), .min_pix_i(min_pix_q), .width_i(width_q), .height_i(height_q),
    .frm_valid_o(frm_valid), .frm_ready_i(frm_ready), .frm_o(frm)
  );

  rbct_divider u_div (
    .clk_i, .rst_ni,
    .frm_valid_i(frm_valid), .frm_ready_o(frm_ready), .frm_i(frm),
    .res_valid_o(res.valid), .res_ready_i(res.ready), .res_o(rs)
  );

  assign res.found     = rs.found;
  assign res.center_x  = rs.center_x;
  assign res.center_y  = rs.center_y;
  assign res.red_count = rs.red_count;
endmodule
`default_nettype wire

[bench/rbct_test_if.sv]
`default_nettype none
// bench-side view of all three channels for the checker
interface rbct_mon_if;
  logic        pix_valid;
  logic        pix_ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_in_frame;
  logic        res_valid;
  logic        res_ready;
  logic        found;
  logic [10:0] center_x;
  logic [10:0] center_y;
  logic [20:0] red_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  index;
  logic [20:0] data;
  modport source (output pix_valid, pix_ready, red, green, blue, last_in_frame,
                  res_valid, res_ready, found, center_x, center_y, red_count,
                  cfg_valid, cfg_ready, index, data);
  modport sink   (input pix_valid, pix_ready, red, green, blue, last_in_frame,
                  res_valid, res_ready, found, center_x, center_y, red_count,
                  cfg_valid, cfg_ready, index, data);
endinterface
`default_nettype wire

[bench/rbct_checker.sv]
`default_nettype none
module rbct_checker (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  rbct_mon_if.sink   mon,
  output int         fail_count_o,
  output int         pending_frames_o
);

  logic [8:0]  hue_lo, hue_hi;
  logic [6:0]  sat_lo, val_lo;
  logic [20:0] min_pix;
  logic [10:0] width_reg, height_reg;
  int unsigned col, row, sx, sy, tally;
  rbct_pkg::result_t frame_q[$];

  function automatic bit pixel_is_red(int unsigned r, int unsigned g, int unsigned b);
    int unsigned mx, mn, d, hue, sat, val;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    d = mx - mn;
    val = mx * 100 / 255;
    sat = (mx == 0) ? 0 : d * 100 / mx;
    if (d == 0) hue = 0;
    else if (r >= g && r >= b) hue = (g >= b) ? 60 * (g - b) / d : (360 * d - 60 * (b - g)) / d;
    else if (b >= g) hue = (b == g) ? (120 * d + 60 * (b - r)) / d : (240 * d + 60 * r - 60 * g) / d;
    else hue = (120 * d + 60 * b - 60 * r) / d;
    return (hue < hue_lo || hue > hue_hi) && sat > sat_lo && val > val_lo;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned m);
    if (v == 0) return 1;
    if (v > m) return m;
    return v;
  endfunction

  function automatic int unsigned add_sat(int unsigned a, int unsigned b);
    return (a + b > 32'(rbct_pkg::SumMax)) ? 32'(rbct_pkg::SumMax) : a + b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w, h;
    rbct_pkg::result_t exp_r, got;
    if (!rst_ni) begin
      hue_lo = 9'd10; hue_hi = 9'd345; sat_lo = 7'd75; val_lo = 7'd75; min_pix = 21'd15;
      width_reg = 11'd640; height_reg = 11'd480;
      col = 0; row = 0; sx = 0; sy = 0; tally = 0;
      fail_count_o = 0;
      pending_frames_o = 0;
      frame_q.delete();
    end else begin
      if (mon.res_valid && mon.res_ready) begin
        got = '{mon.found, mon.center_x, mon.center_y, mon.red_count};
        if (frame_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result beat %p", got);
        end else begin
          exp_r = frame_q.pop_front();
          if (got !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("result mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
      if (mon.pix_valid && mon.pix_ready) begin
        w = clamp_dim(32'(width_reg), 1024);
        h = clamp_dim(32'(height_reg), 1024);
        if (col >= w) col = 0;
        if (row >= h) row = 0;
        if (pixel_is_red(32'(mon.red), 32'(mon.green), 32'(mon.blue)) &&
            tally < 32'(rbct_pkg::TallyMax)) begin
          sx = add_sat(sx, col); sy = add_sat(sy, row); tally++;
        end
        if (mon.last_in_frame) begin
          exp_r.found = tally > min_pix;
          exp_r.center_x = 11'(exp_r.found ? sx / tally : w);
          exp_r.center_y = 11'(exp_r.found ? sy / tally : h);
          exp_r.red_count = 21'(tally);
          frame_q.push_back(exp_r);
          col = 0; row = 0; sx = 0; sy = 0; tally = 0;
        end else begin
          col++;
          if (col >= w) begin
            col = 0; row++;
            if (row >= h) row = 0;
          end
        end
      end
      if (mon.cfg_valid && mon.cfg_ready) begin
        case (rbct_pkg::reg_idx_e'(mon.index))
          rbct_pkg::REG_HUE_LOW:  hue_lo = mon.data[8:0];
          rbct_pkg::REG_HUE_HIGH: hue_hi = mon.data[8:0];
          rbct_pkg::REG_SAT_MIN:  sat_lo = mon.data[6:0];
          rbct_pkg::REG_VAL_MIN:  val_lo = mon.data[6:0];
          rbct_pkg::REG_MIN_PIX:  min_pix = mon.data;
          rbct_pkg::REG_WIDTH:    width_reg = mon.data[10:0];
          rbct_pkg::REG_HEIGHT:   height_reg = mon.data[10:0];
          default: ;
        endcase
      end
      pending_frames_o = frame_q.size();
    end
  end

endmodule
`default_nettype wire

[bench/red_blob_centroid_tracker_test.sv]
`default_nettype none
module red_blob_centroid_tracker_test;

  logic clk_i, rst_ni;
  logic pix_took, cfg_took;
  int   fail_count, pending_frames, cycles;
  int   send_idle, recv_idle;

  rbct_pix_if pix();
  rbct_res_if res();
  rbct_cfg_if cfg();
  rbct_mon_if mon();

  red_blob_centroid_tracker uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pix(pix), .res(res), .cfg(cfg)
  );

  assign mon.pix_valid = pix.valid;
  assign mon.pix_ready = pix.ready;
  assign mon.red = pix.red;
  assign mon.green = pix.green;
  assign mon.blue = pix.blue;
  assign mon.last_in_frame = pix.last_in_frame;
  assign mon.res_valid = res.valid;
  assign mon.res_ready = res.ready;
  assign mon.found = res.found;
  assign mon.center_x = res.center_x;
  assign mon.center_y = res.center_y;
  assign mon.red_count = res.red_count;
  assign mon.cfg_valid = cfg.valid;
  assign mon.cfg_ready = cfg.ready;
  assign mon.index = cfg.index;
  assign mon.data = cfg.data;

  rbct_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .mon(mon.sink),
    .fail_count_o(fail_count), .pending_frames_o(pending_frames)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    pix_took <= pix.valid && pix.ready;
    cfg_took <= cfg.valid && cfg.ready;
    if (cycles > 400000) begin
      $display("[red_blob_centroid_tracker] ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) res.ready <= ($urandom_range(99) >= recv_idle);

  // valid stays high between back to back beats
  task automatic send_pixel(input int unsigned r, g, b, lst);
    if ($urandom_range(99) < send_idle) begin
      pix.valid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle) @(negedge clk_i);
    end
    pix.valid <= 1'b1; pix.red <= 8'(r); pix.green <= 8'(g); pix.blue <= 8'(b);
    pix.last_in_frame <= 1'(lst);
    @(negedge clk_i);
    while (!pix_took) @(negedge clk_i);
  endtask

  task automatic write_reg(input rbct_pkg::reg_idx_e idx, input int unsigned value);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= 21'(value);
    @(negedge clk_i);
    while (!cfg_took) @(negedge clk_i);
    cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle;
    pix.valid <= 1'b0;
    while (pending_frames != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // mostly saturated reds with random content, some noise
  task automatic random_frame(input int unsigned npix);
    int unsigned r, g, b;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(3) != 0) begin
        r = $urandom_range(255, 200); g = $urandom_range(40); b = $urandom_range(40);
      end else begin
        r = $urandom_range(255); g = $urandom_range(255); b = $urandom_range(255);
      end
      send_pixel(r, g, b, (i == npix - 1) ? 1 : 0);
    end
  endtask

  initial begin
    cycles = 0; send_idle = 0; recv_idle = 0;
    pix.valid = 0; pix.red = 0; pix.green = 0; pix.blue = 0; pix.last_in_frame = 0;
    cfg.valid = 0; cfg.index = rbct_pkg::REG_NONE; cfg.data = 0; res.ready = 0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: small frame, all hue branches, ties, black, white
    write_reg(rbct_pkg::REG_WIDTH, 4); write_reg(rbct_pkg::REG_HEIGHT, 3);
    write_reg(rbct_pkg::REG_MIN_PIX, 0);
    send_pixel(255, 0, 0, 0);     send_pixel(255, 0, 1, 0);
    send_pixel(255, 255, 0, 0);   send_pixel(0, 255, 255, 0);
    send_pixel(0, 255, 0, 0);     send_pixel(10, 0, 255, 0);
    send_pixel(255, 0, 255, 0);   send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 0); send_pixel(200, 20, 0, 0);
    send_pixel(250, 0, 30, 0);    send_pixel(255, 0, 0, 0);
    send_pixel(255, 0, 0, 0);     send_pixel(255, 0, 0, 1);
    send_pixel(0, 0, 0, 1);
    settle();
    write_reg(rbct_pkg::REG_HUE_LOW, 360); write_reg(rbct_pkg::REG_HUE_HIGH, 0);
    write_reg(rbct_pkg::REG_SAT_MIN, 0); write_reg(rbct_pkg::REG_VAL_MIN, 0);
    write_reg(rbct_pkg::REG_WIDTH, 0); write_reg(rbct_pkg::REG_HEIGHT, 0);
    write_reg(rbct_pkg::REG_NONE, 5);
    send_pixel(255, 255, 255, 0); send_pixel(1, 0, 0, 0); send_pixel(128, 128, 0, 1);
    settle();
    write_reg(rbct_pkg::REG_HUE_LOW, 511); write_reg(rbct_pkg::REG_HUE_HIGH, 511);
    write_reg(rbct_pkg::REG_SAT_MIN, 127); write_reg(rbct_pkg::REG_VAL_MIN, 127);
    write_reg(rbct_pkg::REG_MIN_PIX, 21'h1FFFFF); write_reg(rbct_pkg::REG_WIDTH, 2047);
    write_reg(rbct_pkg::REG_HEIGHT, 2047);
    send_pixel(255, 0, 0, 0); send_pixel(255, 0, 0, 1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 58; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 58; end
        default: begin send_idle = 34; recv_idle = 34; end
      endcase
      write_reg(rbct_pkg::REG_HUE_LOW, $urandom_range(40));
      write_reg(rbct_pkg::REG_HUE_HIGH, $urandom_range(359, 300));
      write_reg(rbct_pkg::REG_SAT_MIN, $urandom_range(80));
      write_reg(rbct_pkg::REG_VAL_MIN, $urandom_range(80));
      write_reg(rbct_pkg::REG_MIN_PIX, $urandom_range(12));
      write_reg(rbct_pkg::REG_WIDTH, $urandom_range(9, 1));
      write_reg(rbct_pkg::REG_HEIGHT, $urandom_range(6, 1));
      for (int f = 0; f < 12; f++) random_frame($urandom_range(20, 1));
      settle();
    end
    send_idle = 0; recv_idle = 0;
    write_reg(rbct_pkg::REG_MIN_PIX, 1048576); write_reg(rbct_pkg::REG_WIDTH, 1024);
    write_reg(rbct_pkg::REG_HEIGHT, 1024);
    random_frame(30);
    settle();

    if (fail_count == 0) $display("[red_blob_centroid_tracker] OK");
    else $display("[red_blob_centroid_tracker] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
